### rtl/core/jlt_pkg.sv
// Types, constants and arithmetic helpers shared by the joint transform unit.
`timescale 1ns / 1ps
package jlt_pkg;

  typedef enum logic [1:0] {
    KIND_REVOLUTE   = 2'd0,
    KIND_CONTINUOUS = 2'd1,
    KIND_PRISMATIC  = 2'd2,
    KIND_FIXED      = 2'd3
  } jlt_kind_e;

  typedef enum logic [2:0] {
    REG_KIND  = 3'd0,
    REG_AXIS_X = 3'd1,
    REG_AXIS_Y = 3'd2,
    REG_AXIS_Z = 3'd3,
    REG_LOWER = 3'd4,
    REG_UPPER = 3'd5,
    REG_RSVD6 = 3'd6,
    REG_RSVD7 = 3'd7
  } jlt_reg_e;

  localparam logic signed [31:0] ONE30      = 32'sd1073741824;
  localparam logic signed [31:0] NEG_ONE30  = -32'sd1073741824;
  localparam logic signed [35:0] PI30_W     = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI30_W = 36'sd6746518852;
  localparam logic signed [35:0] HALFPI30_W = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] RST_LOWER  = -32'sd843314857;
  localparam logic signed [31:0] RST_UPPER  = 32'sd843314856;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // rounded half up, shift by 30, saturate to 32 bit signed
  function automatic logic signed [31:0] mul30(input logic signed [32:0] a,
                                               input logic signed [31:0] b);
    logic signed [65:0] prod;
    logic signed [65:0] sh;
    logic signed [31:0] r;
    prod = a * b;
    sh = (prod + 66'sd536870912) >>> 30;
    if (sh > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (sh < -66'sd2147483648) r = 32'sh80000000;
    else r = sh[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) r = ONE30;
    else if (v < -34'sd1073741824) r = NEG_ONE30;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/joint_limit_and_transform_unit.sv
// Joint limit and rigid transform unit: clamp, CORDIC sine/cosine, Rodrigues matrix.
// Takes one position word per cycle and returns one transform word per input,
// valid on the output after CORDIC_STEPS+6 register stages (clamp, two range
// reduction stages, one CORDIC stage per rotation, sign fix, multiply, sum).
// The throughput is one word per clock; the only stall is the output register
// waiting on m_axis_tready, which holds the whole pipeline. Axis products are
// precomputed from the registers, so configuration must settle before the
// next word.
`timescale 1ns / 1ps
module joint_limit_and_transform_unit #(
  parameter int CORDIC_STEPS = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] target_position
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
  // trans_x, trans_y, trans_z; 32 bits each from bit 0 up
  output logic [383:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import jlt_pkg::*;

  localparam int L       = CORDIC_STEPS + 6;
  localparam int ST_FOLD = 2;
  localparam int ST_POST = CORDIC_STEPS + 3;
  localparam int ST_MULT = CORDIC_STEPS + 4;
  localparam int ST_OUT  = CORDIC_STEPS + 5;

  // configuration
  jlt_kind_e          kind_cfg_q;
  logic signed [31:0] ax_q, ay_q, az_q, lower_q, upper_q;
  logic signed [31:0] axx_q, ayy_q, azz_q, axy_q, axz_q, ayz_q;
  logic               cfg_wr;
  jlt_reg_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = jlt_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_cfg_q <= KIND_REVOLUTE;
      ax_q <= '0;
      ay_q <= '0;
      az_q <= ONE30;
      lower_q <= RST_LOWER;
      upper_q <= RST_UPPER;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KIND:   kind_cfg_q <= jlt_kind_e'(pwdata[1:0]);
        REG_AXIS_X: ax_q <= pwdata;
        REG_AXIS_Y: ay_q <= pwdata;
        REG_AXIS_Z: az_q <= pwdata;
        REG_LOWER:  lower_q <= pwdata;
        REG_UPPER:  upper_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KIND:   prdata = {30'd0, kind_cfg_q};
      REG_AXIS_X: prdata = ax_q;
      REG_AXIS_Y: prdata = ay_q;
      REG_AXIS_Z: prdata = az_q;
      REG_LOWER:  prdata = lower_q;
      REG_UPPER:  prdata = upper_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    axx_q <= mul30({ax_q[31], ax_q}, ax_q);
    ayy_q <= mul30({ay_q[31], ay_q}, ay_q);
    azz_q <= mul30({az_q[31], az_q}, az_q);
    axy_q <= mul30({ax_q[31], ax_q}, ay_q);
    axz_q <= mul30({ax_q[31], ax_q}, az_q);
    ayz_q <= mul30({ay_q[31], ay_q}, az_q);
  end

  // pipeline control
  logic [L-1:0]       valid_q;
  jlt_kind_e          kind_q [L];
  logic signed [31:0] pos_q  [L];
  logic               adv;

  assign adv           = !valid_q[ST_OUT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[L-2:0], s_axis_tvalid};
    end
  end

  // stage 0: limit clamp
  logic signed [31:0] pos_in, pos_clamped;
  assign pos_in = s_axis_tdata;
  always_comb begin
    pos_clamped = pos_in;
    if (kind_cfg_q == KIND_REVOLUTE || kind_cfg_q == KIND_PRISMATIC) begin
      if (pos_clamped < lower_q) pos_clamped = lower_q;
      if (pos_clamped > upper_q) pos_clamped = upper_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q[0] <= kind_cfg_q;
      pos_q[0]  <= pos_clamped;
    end
  end

  for (genvar k = 1; k < L; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        kind_q[k] <= kind_q[k-1];
        pos_q[k]  <= pos_q[k-1];
      end
    end
  end

  // stage 1: wrap into [-pi, pi] by whole turns
  logic signed [35:0] wrap_z, wrap_z_q;
  always_comb begin
    wrap_z = {{2{pos_q[0][31]}}, pos_q[0], 2'b00};
    for (int k = 0; k < 3; k++) begin
      if (wrap_z > PI30_W) wrap_z = wrap_z - TWO_PI30_W;
      else if (wrap_z < -PI30_W) wrap_z = wrap_z + TWO_PI30_W;
    end
  end

  // stage 2: fold into [-pi/2, pi/2]
  logic signed [35:0] fold_z;
  logic               fold_flip;
  logic signed [33:0] fold_z_q;
  logic               fold_flip_q;
  always_comb begin
    fold_z    = wrap_z_q;
    fold_flip = 1'b0;
    if (wrap_z_q > HALFPI30_W) begin
      fold_z    = wrap_z_q - PI30_W;
      fold_flip = 1'b1;
    end else if (wrap_z_q < -HALFPI30_W) begin
      fold_z    = wrap_z_q + PI30_W;
      fold_flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wrap_z_q    <= wrap_z;
      fold_z_q    <= fold_z[33:0];
      fold_flip_q <= fold_flip;
    end
  end

  // CORDIC, one rotation per stage
  logic signed [33:0] cx_q [CORDIC_STEPS];
  logic signed [33:0] cy_q [CORDIC_STEPS];
  logic signed [33:0] cz_q [CORDIC_STEPS];
  logic               cf_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [33:0] xi, yi, zi, at;
    logic               fi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = fold_z_q;
      assign fi = fold_flip_q;
    end else begin : g_next
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
      assign fi = cf_q[i-1];
    end
    assign at = $signed({2'b00, atan_val(5'(i))});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (zi >= 0) begin
          cx_q[i] <= xi - (yi >>> i);
          cy_q[i] <= yi + (xi >>> i);
          cz_q[i] <= zi - at;
        end else begin
          cx_q[i] <= xi + (yi >>> i);
          cy_q[i] <= yi - (xi >>> i);
          cz_q[i] <= zi + at;
        end
        cf_q[i] <= fi;
      end
    end
  end

  // sign fix and clamp
  logic signed [31:0] sin_q, cos_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (cf_q[CORDIC_STEPS-1]) begin
        cos_q <= clamp_one(-cx_q[CORDIC_STEPS-1]);
        sin_q <= clamp_one(-cy_q[CORDIC_STEPS-1]);
      end else begin
        cos_q <= clamp_one(cx_q[CORDIC_STEPS-1]);
        sin_q <= clamp_one(cy_q[CORDIC_STEPS-1]);
      end
    end
  end

  // products
  logic signed [32:0] one_minus_c;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, sx_q, sy_q, sz_q, c_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic signed [32:0] s_ext, p_ext;
  assign one_minus_c = 33'sd1073741824 - {cos_q[31], cos_q};
  assign s_ext = {sin_q[31], sin_q};
  assign p_ext = {pos_q[ST_POST][31], pos_q[ST_POST]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= mul30(one_minus_c, axx_q);
      yy_q <= mul30(one_minus_c, ayy_q);
      zz_q <= mul30(one_minus_c, azz_q);
      xy_q <= mul30(one_minus_c, axy_q);
      xz_q <= mul30(one_minus_c, axz_q);
      yz_q <= mul30(one_minus_c, ayz_q);
      sx_q <= mul30(s_ext, ax_q);
      sy_q <= mul30(s_ext, ay_q);
      sz_q <= mul30(s_ext, az_q);
      tx_q <= mul30(p_ext, ax_q);
      ty_q <= mul30(p_ext, ay_q);
      tz_q <= mul30(p_ext, az_q);
      c_q  <= cos_q;
    end
  end

  // sums and output register
  logic signed [31:0] rot_q [9];
  logic signed [31:0] tr_q  [3];
  logic signed [31:0] rot_d [9];
  logic signed [31:0] tr_d  [3];
  jlt_kind_e          mk;
  assign mk = kind_q[ST_MULT];

  function automatic logic signed [33:0] add34(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {{2{a[31]}}, a} + {{2{b[31]}}, b};
  endfunction

  function automatic logic signed [33:0] sub34(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {{2{a[31]}}, a} - {{2{b[31]}}, b};
  endfunction

  always_comb begin
    for (int j = 0; j < 9; j++) rot_d[j] = '0;
    for (int j = 0; j < 3; j++) tr_d[j] = '0;
    rot_d[0] = ONE30;
    rot_d[4] = ONE30;
    rot_d[8] = ONE30;
    case (mk)
      KIND_REVOLUTE, KIND_CONTINUOUS: begin
        rot_d[0] = clamp_one(add34(c_q, xx_q));
        rot_d[1] = clamp_one(sub34(xy_q, sz_q));
        rot_d[2] = clamp_one(add34(xz_q, sy_q));
        rot_d[3] = clamp_one(add34(xy_q, sz_q));
        rot_d[4] = clamp_one(add34(c_q, yy_q));
        rot_d[5] = clamp_one(sub34(yz_q, sx_q));
        rot_d[6] = clamp_one(sub34(xz_q, sy_q));
        rot_d[7] = clamp_one(add34(yz_q, sx_q));
        rot_d[8] = clamp_one(add34(c_q, zz_q));
      end
      KIND_PRISMATIC: begin
        tr_d[0] = tx_q;
        tr_d[1] = ty_q;
        tr_d[2] = tz_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rot_q <= rot_d;
      tr_q  <= tr_d;
    end
  end

  assign m_axis_tdata = {tr_q[2], tr_q[1], tr_q[0],
                         rot_q[8], rot_q[7], rot_q[6], rot_q[5], rot_q[4],
                         rot_q[3], rot_q[2], rot_q[1], rot_q[0]};

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline moved during stall");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_POST] |-> (cos_q <= ONE30 && cos_q >= NEG_ONE30 &&
                          sin_q <= ONE30 && sin_q >= NEG_ONE30))
    else $error("sine or cosine out of range");

  a_fixed_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_OUT] && kind_q[ST_OUT] == KIND_FIXED) |->
      (rot_q[0] == ONE30 && rot_q[1] == 0 && tr_q[0] == 0 && tr_q[2] == 0))
    else $error("fixed joint not identity");

  a_rot_trans_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_OUT] && (kind_q[ST_OUT] == KIND_REVOLUTE ||
                         kind_q[ST_OUT] == KIND_CONTINUOUS)) |->
      (tr_q[0] == 0 && tr_q[1] == 0 && tr_q[2] == 0))
    else $error("rotating joint with translation");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_FOLD] |-> (fold_z_q <= 34'sd1686629713 && fold_z_q >= -34'sd1686629713))
    else $error("angle fold out of range");

endmodule

### sim/tb_joint_limit_and_transform_unit.sv
// Self-checking testbench for the joint limit and transform unit.
`timescale 1ns / 1ps
module tb_joint_limit_and_transform_unit;
  import jlt_pkg::*;

  localparam int STEPS = 30;
  localparam int LATENCY = STEPS + 10;
  localparam logic signed [63:0] PI_Q = 64'sd3373259426;
  localparam logic signed [63:0] HPI_Q = 64'sd1686629713;
  localparam logic signed [63:0] ONE_Q = 64'sd1073741824;

  typedef struct {
    logic [31:0] pos;
    logic        chk;
    logic [383:0] word;
  } row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [383:0] m_axis_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  joint_limit_and_transform_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  jlt_kind_e cur_kind;
  logic signed [63:0] ax, ay, az, lo_lim, hi_lim;
  logic [383:0] expected_words[$];
  int fails = 0;
  bit hold_off = 0;

  function automatic logic signed [63:0] lim64(logic signed [63:0] v,
      logic signed [63:0] lo, logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = (128'(a) * 128'(b) + 128'sd536870912) >>> 30;
    return lim64(64'(p), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic logic [383:0] predict_word(logic [31:0] cmd);
    logic signed [63:0] r[12];
    logic signed [63:0] p, z, x, y, nx, s, c, t;
    logic signed [63:0] xx, yy, zz, xy, xz, yz, sx, sy, sz;
    logic flip;
    logic [383:0] w;
    p = 64'(signed'(cmd));
    foreach (r[j]) r[j] = 0;
    r[0] = ONE_Q; r[4] = ONE_Q; r[8] = ONE_Q;
    if (cur_kind == KIND_REVOLUTE || cur_kind == KIND_PRISMATIC) begin
      if (p < lo_lim) p = lo_lim;
      if (p > hi_lim) p = hi_lim;
    end
    if (cur_kind == KIND_REVOLUTE || cur_kind == KIND_CONTINUOUS) begin
      z = p * 4; x = 64'sd652032874; y = 0; flip = 0;
      for (int k = 0; k < 3; k++) begin
        if (z > PI_Q) z -= 2 * PI_Q;
        else if (z < -PI_Q) z += 2 * PI_Q;
      end
      if (z > HPI_Q) begin
        z -= PI_Q; flip = 1;
      end else if (z < -HPI_Q) begin
        z += PI_Q; flip = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= (i == 31) ? 0 : 64'(atan_val(5'(i)));
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += (i == 31) ? 0 : 64'(atan_val(5'(i)));
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = lim64(x, -ONE_Q, ONE_Q);
      s = lim64(y, -ONE_Q, ONE_Q);
      t = ONE_Q - c;
      xx = qmul(t, qmul(ax, ax)); yy = qmul(t, qmul(ay, ay)); zz = qmul(t, qmul(az, az));
      xy = qmul(t, qmul(ax, ay)); xz = qmul(t, qmul(ax, az)); yz = qmul(t, qmul(ay, az));
      sx = qmul(s, ax); sy = qmul(s, ay); sz = qmul(s, az);
      r[0] = c + xx; r[1] = xy - sz; r[2] = xz + sy;
      r[3] = xy + sz; r[4] = c + yy; r[5] = yz - sx;
      r[6] = xz - sy; r[7] = yz + sx; r[8] = c + zz;
      for (int j = 0; j < 9; j++) r[j] = lim64(r[j], -ONE_Q, ONE_Q);
    end else if (cur_kind == KIND_PRISMATIC) begin
      r[9] = qmul(ax, p); r[10] = qmul(ay, p); r[11] = qmul(az, p);
    end
    for (int j = 0; j < 12; j++) w[32*j +: 32] = r[j][31:0];
    return w;
  endfunction

  task automatic apb_write(jlt_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) * 5'd4; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_KIND:   cur_kind = jlt_kind_e'(val[1:0]);
      REG_AXIS_X: ax = 64'(signed'(val));
      REG_AXIS_Y: ay = 64'(signed'(val));
      REG_AXIS_Z: az = 64'(signed'(val));
      REG_LOWER:  lo_lim = 64'(signed'(val));
      REG_UPPER:  hi_lim = 64'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic setup_joint(jlt_kind_e k, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] lo, logic [31:0] hi);
    apb_write(REG_KIND, 32'(k));
    apb_write(REG_AXIS_X, x);
    apb_write(REG_AXIS_Y, y);
    apb_write(REG_AXIS_Z, z);
    apb_write(REG_LOWER, lo);
    apb_write(REG_UPPER, hi);
  endtask

  task automatic send_word(logic [31:0] pos, logic [383:0] exp_w);
    expected_words.push_back(exp_w);
    s_axis_tdata <= pos;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      logic [31:0] pos;
      case ($urandom_range(0, 3))
        0: pos = $urandom;
        1: pos = 32'(signed'(lo_lim)) + $urandom_range(0, 1000) - 500;
        2: pos = 32'(signed'(hi_lim)) + $urandom_range(0, 1000) - 500;
        default: pos = 32'($signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000);
      endcase
      send_word(pos, predict_word(pos));
      if (burst <= 0) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
          s_axis_tvalid <= 0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst--;
    end
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [383:0] ident_word;
    logic [383:0] w;
    w = '0;
    w[31:0] = ONE30; w[4*32 +: 32] = ONE30; w[8*32 +: 32] = ONE30;
    return w;
  endfunction

  // receiver: stall pattern plus a long hold-off
  initial begin
    int phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off) m_axis_tready <= 0;
      else if (phase % 64 < 24) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // checker
  initial begin
    logic [383:0] e;
    string names[12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                         "rot_20", "rot_21", "rot_22", "trans_x", "trans_y", "trans_z"};
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word"); fails++;
        end else begin
          e = expected_words.pop_front();
          for (int j = 0; j < 12; j++)
            if (e[32*j +: 32] !== m_axis_tdata[32*j +: 32]) begin
              $error("%s exp %0d got %0d", names[j], $signed(e[32*j +: 32]),
                     $signed(m_axis_tdata[32*j +: 32]));
              fails++;
            end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** joint_limit_and_transform_unit: FAILED **");
    $finish;
  end

  initial begin
    row_t dir[$];
    logic [383:0] w;
    cur_kind = KIND_REVOLUTE; ax = 0; ay = 0; az = ONE30;
    lo_lim = -64'sd843314857; hi_lim = 64'sd843314856;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;

    // directed: reset config, zero angle and extremes
    dir.push_back('{32'h0, 0, '0});
    dir.push_back('{32'h7FFF_FFFF, 0, '0});
    dir.push_back('{32'h8000_0000, 0, '0});
    dir.push_back('{32'h3243_F6A8, 0, '0});
    foreach (dir[i]) send_word(dir[i].pos, dir[i].chk ? dir[i].word : predict_word(dir[i].pos));
    s_axis_tvalid <= 0;
    drain();

    // fixed joint ignores command
    setup_joint(KIND_FIXED, 32'h4000_0000, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFF, ident_word());
    send_word(32'h8000_0000, ident_word());
    s_axis_tvalid <= 0;
    drain();

    // prismatic, full limits, axis (1, -1, 0): translation extremes
    setup_joint(KIND_PRISMATIC, 32'h4000_0000, 32'hC000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    w = ident_word(); w[9*32 +: 32] = 32'h7FFF_FFFF; w[10*32 +: 32] = 32'h8000_0001;
    send_word(32'h7FFF_FFFF, w);
    send_word(32'h8000_0000, predict_word(32'h8000_0000));
    s_axis_tvalid <= 0;
    drain();

    // crossed limits end at upper
    setup_joint(KIND_REVOLUTE, 0, 32'h4000_0000, 0, 32'h1000_0000, 32'hF000_0000);
    send_word(32'h8000_0000, predict_word(32'h8000_0000));
    send_word(32'h0, predict_word(32'h0));
    s_axis_tvalid <= 0;
    drain();

    // continuous, oversized axis saturates
    setup_joint(KIND_CONTINUOUS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 0, 0);
    foreach (dir[i]) send_word(dir[i].pos, predict_word(dir[i].pos));
    s_axis_tvalid <= 0;
    drain();

    // random phases, bits of each register exercised by random axes
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] lo, hi;
      lo = $urandom; hi = $urandom;
      if ($urandom_range(0, 3) != 0 && $signed(lo) > $signed(hi)) {lo, hi} = {hi, lo};
      if (ph % 2 == 0)
        setup_joint(jlt_kind_e'(ph % 4 == 0 ? KIND_REVOLUTE : $urandom_range(0, 3)),
                    32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000),
                    32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000),
                    32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000), lo, hi);
      else
        setup_joint(jlt_kind_e'(ph % 4 == 1 ? KIND_CONTINUOUS : KIND_PRISMATIC),
                    $urandom, $urandom, $urandom, lo, hi);
      if (ph == 3) fork
        begin
          hold_off = 1;
          repeat (300) @(negedge clk_i);
          hold_off = 0;
        end
      join_none
      run_random(210);
      drain();
    end

    if (fails == 0) $display("** joint_limit_and_transform_unit: PASSED **");
    else $display("** joint_limit_and_transform_unit: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/core/jlt_pkg.sv
rtl/core/joint_limit_and_transform_unit.sv
sim/tb_joint_limit_and_transform_unit.sv
